// File: hw/rtl/cenc_k7_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cenc_k7_pkg: shared types and constants of the K=7 word-parallel encoder
// Field widths, register map, reset values and the delay helper.
// ----------------------------------------------------------------------------
package cenc_k7_pkg;

  localparam int unsigned DATA_W          = 64;
  localparam int unsigned HIST_W          = 6;
  localparam int unsigned SYM_W           = 13;
  localparam int unsigned LOG_DATA_W      = 6;
  localparam int unsigned CFG_DATA_W      = 32;
  localparam int unsigned CFG_ADDR_W      = 3;
  localparam int unsigned MAX_SYMBOL_BITS_DEF = 4096;

  localparam logic [SYM_W-1:0] SYM_BITS_RESET = SYM_W'(24);

  // Register index decode (paddr[2] is the word index)
  localparam logic REG_SYMBOL_BITS = 1'b0;

  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    word_t code_b;
    word_t code_a;
    logic  last;
  } result_t;

  // Stream delayed by d bits, older bits taken from the history
  function automatic word_t delayed(input logic [HIST_W+DATA_W-1:0] ext,
                                    input int unsigned d);
    delayed = ext[d +: DATA_W];
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/conv_encoder_k7_word_parallel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// conv_encoder_k7_word_parallel: rate 1/2, K=7 encoder (133/171), 64 bits a word
// Encodes a whole word per cycle while in_tready is high, against a six-bit
// history, masks the tail of the last word of a symbol and flags it with tlast.
// ----------------------------------------------------------------------------
// Results are registered (result register, or skid register on a stall) before out_t*.
// Throughput: one word per cycle unless skid is full; the six-bit history loop sits in hist_r.
// A two-entry output buffer (result register plus skid register) keeps
// in_tready a register, so input keeps flowing while one result waits.
// Reset (rst_n low, synchronous): history, word count and buffer empty,
// symbol_bits back to 24.

module conv_encoder_k7_word_parallel #(
  parameter int unsigned MAX_SYMBOL_BITS = cenc_k7_pkg::MAX_SYMBOL_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [cenc_k7_pkg::DATA_W-1:0]      in_tdata,   // [63:0] data_word
  input  wire logic                                in_tuser,   // [0] frame_start
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [2*cenc_k7_pkg::DATA_W-1:0]         out_tdata,  // [63:0] code_a, [127:64] code_b
  output logic                                     out_tlast,  // symbol_last
  // configuration
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [cenc_k7_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [cenc_k7_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cenc_k7_pkg::CFG_DATA_W-1:0]       cfg_prdata,
  output logic                                     cfg_pready
);
  import cenc_k7_pkg::*;

  localparam int unsigned MAX_WORDS = (MAX_SYMBOL_BITS + DATA_W - 1) / DATA_W;
  localparam int unsigned IDX_W     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned WORDS_W   = SYM_W - LOG_DATA_W + 1;
  localparam int unsigned CMP_W     = (IDX_W + 1 > WORDS_W) ? IDX_W + 1 : WORDS_W;
  localparam int unsigned CLAMP_W   = 18;

  // configuration
  logic [SYM_W-1:0] sym_bits_r;
  logic             cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready
                    & (cfg_paddr[2] == REG_SYMBOL_BITS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= SYM_BITS_RESET;
    end else if (cfg_wr) begin
      sym_bits_r <= cfg_pwdata[SYM_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_SYMBOL_BITS) begin
      cfg_prdata = CFG_DATA_W'(sym_bits_r);
    end
  end

  // symbol geometry
  logic [SYM_W-1:0]      eff_bits;
  logic [WORDS_W-1:0]    num_words;
  logic [LOG_DATA_W-1:0] tail;

  always_comb begin
    if (sym_bits_r == '0) begin
      eff_bits = SYM_W'(1);
    end else if (CLAMP_W'(sym_bits_r) > CLAMP_W'(MAX_SYMBOL_BITS)) begin
      eff_bits = SYM_W'(MAX_SYMBOL_BITS);
    end else begin
      eff_bits = sym_bits_r;
    end
    num_words = WORDS_W'(eff_bits[SYM_W-1:LOG_DATA_W])
              + WORDS_W'(eff_bits[LOG_DATA_W-1:0] != '0);
    tail      = LOG_DATA_W'(0) - eff_bits[LOG_DATA_W-1:0];
  end

  // encoder datapath
  logic [HIST_W-1:0]        hist_r, hist_nxt;
  logic [IDX_W-1:0]         word_idx_r, word_idx_nxt;
  logic [HIST_W-1:0]        hist_cur;
  logic [IDX_W-1:0]         idx_cur;
  logic [HIST_W+DATA_W-1:0] ext;
  word_t                    shared, mask;
  logic                     is_last;
  result_t                  res;
  logic                     in_xfer, out_xfer;

  assign in_xfer  = in_tvalid & in_tready;
  assign out_xfer = out_tvalid & out_tready;

  always_comb begin
    hist_cur = in_tuser ? '0 : hist_r;
    idx_cur  = in_tuser ? '0 : word_idx_r;
    ext      = {hist_cur, in_tdata};
    shared   = in_tdata ^ delayed(ext, 2) ^ delayed(ext, 3) ^ delayed(ext, 6);
    is_last  = (CMP_W'(idx_cur) + CMP_W'(1)) >= CMP_W'(num_words);
    mask     = is_last ? ({DATA_W{1'b1}} << tail) : {DATA_W{1'b1}};
    res.code_a = (shared ^ delayed(ext, 5)) & mask;
    res.code_b = (shared ^ delayed(ext, 1)) & mask;
    res.last   = is_last;
    // on the last word, the history ends at the last valid bit
    hist_nxt     = is_last ? ext[tail +: HIST_W] : in_tdata[HIST_W-1:0];
    word_idx_nxt = is_last ? '0 : idx_cur + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r     <= '0;
      word_idx_r <= '0;
    end else if (in_xfer) begin
      hist_r     <= hist_nxt;
      word_idx_r <= word_idx_nxt;
    end
  end

  // output register plus skid register
  result_t out_r, skid_r;
  logic    out_valid_r, skid_valid_r;

  assign in_tready = ~skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_xfer) begin
        // advance skid into the result register, or refill from input
        out_valid_r  <= skid_valid_r | in_xfer;
        skid_valid_r <= 1'b0;
      end else if (in_xfer) begin
        if (out_valid_r) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r  <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_xfer) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (in_xfer && !out_valid_r) begin
      out_r <= res;
    end
    if (in_xfer && out_valid_r && !out_xfer) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.code_b, out_r.code_a};
  assign out_tlast  = out_r.last;

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_valid_r) |-> $past(out_valid_r && !out_tready))
    else $error("skid register filled while the output was free");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(word_idx_r) < MAX_WORDS)
    else $error("word index beyond the longest symbol");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && is_last) |=> (word_idx_r == '0))
    else $error("word count not restarted after the last word of a symbol");

endmodule
`default_nettype wire
